[design/url_percent_encoder_unit_assert.svh]
// Assertion macros used by the design checker, upe_checker.sv.
`ifndef URL_PERCENT_ENCODER_UNIT_ASSERT_SVH
`define URL_PERCENT_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define UPE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upe assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define UPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upe assertion failed");

`endif

[design/upe_pkg.sv]
`default_nettype none

package upe_pkg;

    // Width of the running output count.
    localparam int COUNT_BITS = 16;
    // Compare width: wide enough for the count or the 16-bit limit, plus headroom.
    localparam int CMP_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] PERCENT_CHAR = 8'h25;

    typedef enum logic [1:0] {
        JOB_STATUS  = 2'd0,
        JOB_LITERAL = 2'd1,
        JOB_ESCAPE  = 2'd2
    } job_kind_t;

    // One classified request handed from the front end to the back end.
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
        logic       last;
        logic       truncated;
    } job_t;

    function automatic logic is_unreserved(input logic [7:0] b);
        logic hit;
        begin
            case (b) inside
                [8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                8'h2D, 8'h2E, 8'h5F, 8'h7E: hit = 1'b1;
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

    // Number of bytes in the UTF-8 sequence that this byte opens.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        begin
            case (b) inside
                [8'hC2:8'hDF]: n = 3'd2;
                [8'hE0:8'hEF]: n = 3'd3;
                [8'hF0:8'hF7]: n = 3'd4;
                [8'hF8:8'hFB]: n = 3'd5;
                [8'hFC:8'hFD]: n = 3'd6;
                default:       n = 3'd1;
            endcase
            return n;
        end
    endfunction

    // Output bytes reserved by an escaped sequence of the given length.
    function automatic logic [4:0] seq_cost(input logic [2:0] n);
        logic [4:0] c;
        begin
            case (n)
                3'd2:    c = 5'd6;
                3'd3:    c = 5'd9;
                3'd4:    c = 5'd12;
                3'd5:    c = 5'd15;
                3'd6:    c = 5'd18;
                default: c = 5'd3;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        begin
            if (v < 4'd10)
                return 8'h30 + {4'b0, v};
            else
                return 8'h37 + {4'b0, v};
        end
    endfunction

endpackage

`default_nettype wire

[design/url_percent_encoder_unit.sv]
// Channel | Handshake           | Payload
// input   | in_valid / in_stall | in_byte, string_end
// output  | out_valid/out_stall | out_byte, byte_valid, run_last, string_last, truncated
// config  | APB write/read      | max_value_size at byte address 0
//
// An input request is classified in the cycle it is accepted and, unless the limit
// drops it, occupies one slot of a four-entry queue; the output side drains one
// result per cycle while not stalled. An unreserved byte gives one result, an escaped
// byte three, a status-only end marker one; the output port sets the sustained rate.
// The input side stalls only when the queue is full; the output register holds a
// stalled result while the queue keeps filling. Reset clears all string state.
`default_nettype none

module url_percent_encoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        string_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             run_last,
    output logic             string_last,
    output logic             truncated,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import upe_pkg::*;

    // Word index of the size limit register.
    localparam logic REG_MAX_SIZE = 1'b0;

    logic [15:0] max_size_reg;
    logic        cfg_write;

    logic        queue_full;
    logic        queue_empty;
    logic        push;
    logic        pop;
    job_t        push_job;
    job_t        head_job;

    // Register file: a single word, writable in the access phase only.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MAX_SIZE) ? {16'b0, max_size_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_size_reg <= 16'd4096;
        else if (cfg_write && paddr[2] == REG_MAX_SIZE)
            max_size_reg <= pwdata[15:0];
    end

    // Front end: tracks the running count, the open UTF-8 sequence and the stop flag.
    upe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .string_end     (string_end),
        .max_value_size (max_size_reg),
        .queue_full     (queue_full),
        .push           (push),
        .push_job       (push_job)
    );

    upe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .head     (head_job),
        .empty    (queue_empty)
    );

    // Back end: expands each queued request into one or three output bytes.
    upe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_job),
        .empty       (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .run_last    (run_last),
        .string_last (string_last),
        .truncated   (truncated)
    );

endmodule

`default_nettype wire

[design/upe_front.sv]
`default_nettype none

module upe_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   in_byte,
    input  wire logic                         string_end,
    input  wire logic [15:0]                  max_value_size,
    input  wire logic                         queue_full,
    output logic                              push,
    output upe_pkg::job_t                     push_job
);
    import upe_pkg::*;

    localparam logic [CMP_BITS-1:0] COUNT_MAX =
        {{(CMP_BITS-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;
    logic [2:0]            seq_rem_reg, seq_rem_next;
    logic                  stopped_reg, stopped_next;

    logic                  accept;
    logic [2:0]            lead_n;
    logic                  needs_escape;
    logic [4:0]            cost;
    logic [CMP_BITS-1:0]   max_ext;
    logic [CMP_BITS-1:0]   limit;
    logic [CMP_BITS-1:0]   need;
    logic                  over;
    job_kind_t             kind;
    logic                  emit;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    assign lead_n       = lead_length(in_byte);
    assign needs_escape = (lead_n != 3'd1) || !is_unreserved(in_byte);
    assign cost         = needs_escape ? seq_cost(lead_n) : 5'd1;
    assign max_ext      = CMP_BITS'(max_value_size);
    assign limit        = (max_ext > COUNT_MAX) ? COUNT_MAX : max_ext;
    assign need         = CMP_BITS'(out_count_reg) + CMP_BITS'(cost);
    assign over         = need > limit;

    always_comb
    begin
        out_count_next = out_count_reg;
        seq_rem_next   = seq_rem_reg;
        stopped_next   = stopped_reg;
        kind           = JOB_STATUS;
        emit           = 1'b0;
        if (!stopped_reg) begin
            if (seq_rem_reg != 3'd0) begin
                // Continuation bytes were reserved by the lead byte's check.
                emit           = 1'b1;
                kind           = JOB_ESCAPE;
                out_count_next = out_count_reg + COUNT_BITS'(3);
                seq_rem_next   = seq_rem_reg - 3'd1;
            end else if (over) begin
                stopped_next = 1'b1;
            end else if (needs_escape) begin
                emit           = 1'b1;
                kind           = JOB_ESCAPE;
                out_count_next = out_count_reg + COUNT_BITS'(3);
                seq_rem_next   = lead_n - 3'd1;
            end else begin
                emit           = 1'b1;
                kind           = JOB_LITERAL;
                out_count_next = out_count_reg + COUNT_BITS'(1);
            end
        end
    end

    assign push     = accept && (emit || string_end);
    assign push_job = '{kind: kind, data: in_byte, last: string_end, truncated: stopped_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_count_reg <= '0;
            seq_rem_reg   <= '0;
            stopped_reg   <= 1'b0;
        end else if (accept) begin
            if (string_end) begin
                out_count_reg <= '0;
                seq_rem_reg   <= '0;
                stopped_reg   <= 1'b0;
            end else begin
                out_count_reg <= out_count_next;
                seq_rem_reg   <= seq_rem_next;
                stopped_reg   <= stopped_next;
            end
        end
    end

endmodule

`default_nettype wire

[design/upe_queue.sv]
`default_nettype none

module upe_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire upe_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output upe_pkg::job_t      head,
    output logic               empty
);
    import upe_pkg::*;

    job_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   fill_reg;
    logic                 do_pop;

    assign full   = fill_reg == (QPTR_BITS+1)'(QUEUE_DEPTH);
    assign empty  = fill_reg == '0;
    assign head   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            if ((push && !full) && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (!(push && !full) && do_pop)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

[design/upe_back.sv]
`default_nettype none

module upe_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire upe_pkg::job_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               run_last,
    output logic               string_last,
    output logic               truncated
);
    import upe_pkg::*;

    typedef enum logic [2:0] {
        PH_PCT = 3'b001,
        PH_HI  = 3'b010,
        PH_LO  = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       bvalid_reg, run_last_reg, str_last_reg, trunc_reg;

    logic       load;
    logic       produce;
    logic       item_last;
    logic [7:0] byte_next;

    assign load    = !out_valid_reg || !out_stall;
    assign produce = load && !empty;

    always_comb
    begin
        phase_next = phase_reg;
        item_last  = 1'b1;
        byte_next  = 8'h00;
        case (head.kind)
            JOB_LITERAL: byte_next = head.data;
            JOB_ESCAPE:
            begin
                case (phase_reg)
                    PH_PCT:
                    begin
                        byte_next  = PERCENT_CHAR;
                        item_last  = 1'b0;
                        phase_next = PH_HI;
                    end
                    PH_HI:
                    begin
                        byte_next  = hex_digit(head.data[7:4]);
                        item_last  = 1'b0;
                        phase_next = PH_LO;
                    end
                    default:
                    begin
                        byte_next  = hex_digit(head.data[3:0]);
                        phase_next = PH_PCT;
                    end
                endcase
            end
            default: byte_next = 8'h00;
        endcase
    end

    assign pop = produce && item_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_PCT;
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= !empty;
            if (!empty)
                phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce) begin
            byte_reg     <= byte_next;
            bvalid_reg   <= head.kind != JOB_STATUS;
            run_last_reg <= item_last;
            str_last_reg <= item_last && head.last;
            trunc_reg    <= head.truncated;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign byte_valid  = bvalid_reg;
    assign run_last    = run_last_reg;
    assign string_last = str_last_reg;
    assign truncated   = trunc_reg;

endmodule

`default_nettype wire

[design/upe_checker.sv]
`default_nettype none

`include "url_percent_encoder_unit_assert.svh"

module upe_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       byte_valid,
    input wire logic       run_last,
    input wire logic       string_last,
    input wire logic       truncated
);

    // A status-only result only ever closes a string.
    `UPE_ASSERT_IMPLY(a_status_closes, clk, rst_n, out_valid && !byte_valid, run_last && string_last)

    // The end of a string is always the end of its byte's results.
    `UPE_ASSERT_IMPLY(a_last_is_run_end, clk, rst_n, out_valid && string_last, run_last)

    // Data is only produced before the limit stops the string.
    `UPE_ASSERT_IMPLY(a_data_not_truncated, clk, rst_n, out_valid && byte_valid, !truncated)

    // A stalled result stays on the port unchanged.
    `UPE_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte))

endmodule

bind url_percent_encoder_unit upe_checker u_upe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .run_last    (run_last),
    .string_last (string_last),
    .truncated   (truncated)
);

`default_nettype wire

[dv/url_encoder_checker.sv]
`timescale 1ns / 1ps

module url_encoder_checker #(
    parameter logic [2:0] REG_ADDR = 3'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        string_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        byte_valid,
    input  logic        run_last,
    input  logic        string_last,
    input  logic        truncated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          error_count,
    output int          chars_owed,
    output int          results_checked,
    output int          cut_results
);

    localparam logic [15:0] LIMIT_AT_RESET = 16'd4096;
    localparam logic [7:0]  PERCENT = 8'h25;
    localparam longint unsigned COUNT_MAX = (64'd1 << upe_pkg::COUNT_BITS) - 64'd1;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_data;
        logic       run_end;
        logic       str_end;
        logic       cut;
    } enc_result_t;

    enc_result_t     expected_chars[$];
    logic [15:0]     size_limit;
    longint unsigned emitted;
    int unsigned     seq_left;
    bit              halted;

    function automatic bit keeps_form(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h2E ||
               b == 8'h5F || b == 8'h7E;
    endfunction

    function automatic int unsigned seq_span(input logic [7:0] b);
        if (b >= 8'hC2 && b <= 8'hDF) return 2;
        if (b >= 8'hE0 && b <= 8'hEF) return 3;
        if (b >= 8'hF0 && b <= 8'hF7) return 4;
        if (b >= 8'hF8 && b <= 8'hFB) return 5;
        if (b >= 8'hFC && b <= 8'hFD) return 6;
        return 1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h41 + {4'h0, v} - 8'd10);
    endfunction

    function automatic int field_mismatch(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Works out the results of one accepted request and queues them in order.
    task automatic encode_request(input logic [7:0] b, input logic fin);
        enc_result_t     step_q[$];
        enc_result_t     r;
        longint unsigned cap;
        int unsigned     span;
        int              last_i;
        bit              esc;
        bit              lit;
        cap = (size_limit > COUNT_MAX) ? COUNT_MAX : size_limit;
        r = '0;
        esc = 0;
        lit = 0;
        if (!halted) begin
            if (seq_left != 0) begin
                // Continuation bytes were paid for when the lead byte was checked.
                esc = 1;
                seq_left--;
            end else begin
                span = seq_span(b);
                if (span > 1 || !keeps_form(b)) begin
                    if (emitted + 3 * span > cap)
                        halted = 1;
                    else begin
                        esc = 1;
                        seq_left = span - 1;
                    end
                end else if (emitted + 1 > cap)
                    halted = 1;
                else
                    lit = 1;
            end
        end
        if (esc) begin
            r.has_data = 1'b1;
            r.ch = PERCENT;
            step_q.push_back(r);
            r.ch = hex_char(b[7:4]);
            step_q.push_back(r);
            r.ch = hex_char(b[3:0]);
            step_q.push_back(r);
            emitted += 3;
        end else if (lit) begin
            r.has_data = 1'b1;
            r.ch = b;
            step_q.push_back(r);
            emitted += 1;
        end else if (fin) begin
            step_q.push_back(r);
        end
        foreach (step_q[i])
            step_q[i].cut = halted;
        if (step_q.size() > 0) begin
            last_i = step_q.size() - 1;
            step_q[last_i].run_end = 1'b1;
            step_q[last_i].str_end = fin;
        end
        foreach (step_q[i])
            expected_chars.push_back(step_q[i]);
        if (fin) begin
            emitted = 0;
            seq_left = 0;
            halted = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        enc_result_t want;
        int          bad;
        if (!rst_n) begin
            expected_chars.delete();
            size_limit = LIMIT_AT_RESET;
            emitted = 0;
            seq_left = 0;
            halted = 0;
            error_count <= 0;
            chars_owed <= 0;
            results_checked <= 0;
            cut_results <= 0;
        end else begin
            bad = 0;
            if (out_valid && !out_stall) begin
                if (expected_chars.size() == 0) begin
                    $error("result with no request pending: out_byte 0x%0h", out_byte);
                    bad = 1;
                end else begin
                    want = expected_chars.pop_front();
                    bad += field_mismatch("out_byte", want.ch, out_byte);
                    bad += field_mismatch("byte_valid", want.has_data, byte_valid);
                    bad += field_mismatch("run_last", want.run_end, run_last);
                    bad += field_mismatch("string_last", want.str_end, string_last);
                    bad += field_mismatch("truncated", want.cut, truncated);
                    cut_results <= cut_results + int'(want.cut);
                end
                results_checked <= results_checked + 1;
            end
            if (psel && penable && pready && paddr == REG_ADDR) begin
                if (pwrite)
                    size_limit = pwdata[15:0];
                else
                    bad += field_mismatch("prdata", {16'h0, size_limit}, prdata);
            end
            if (in_valid && !in_stall)
                encode_request(in_byte, string_end);
            chars_owed <= expected_chars.size();
            error_count <= error_count + bad;
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    // The size limit is the only register and sits at byte address zero.
    localparam logic [2:0] MAX_SIZE_ADDR = 3'd0;
    localparam int CYCLE_LIMIT = 200000;
    // A dropped request leaves no result behind, so after the last result the
    // block may still be busy; this wait covers a full queue of escaped bytes,
    // with margin.
    localparam int HOLD_OFF = 24;
    localparam int RANDOM_ITEMS = 72;
    localparam int SEGMENTS = 8;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        string_end = 1'b0;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'h0;

    logic        in_stall;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        string_last;
    logic        truncated;
    logic [31:0] prdata;
    logic        pready;

    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int strings_sent = 0;
    int cycles = 0;

    int error_count;
    int chars_owed;
    int results_checked;
    int cut_results;

    // Bytes of the string that is about to be sent.
    logic [7:0] text_q[$];

    url_percent_encoder_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .string_end  (string_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .run_last    (run_last),
        .string_last (string_last),
        .truncated   (truncated),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // The checker sits beside the block, watches both channels and the register
    // port, predicts every result and hands back the failure count.
    url_encoder_checker #(
        .REG_ADDR (MAX_SIZE_ADDR)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_byte         (in_byte),
        .string_end      (string_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .byte_valid      (byte_valid),
        .run_last        (run_last),
        .string_last     (string_last),
        .truncated       (truncated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .error_count     (error_count),
        .chars_owed      (chars_owed),
        .results_checked (results_checked),
        .cut_results     (cut_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver decides afresh at every falling edge whether to stall.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is accepted. The valid
    // stays high afterwards, so back-to-back requests need no lowering in between;
    // the next call either changes the payload or drops valid for an idle cycle.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        string_end <= fin;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        if (fin)
            strings_sent++;
    endtask

    // Sends the prepared string, marking its last byte as the string end.
    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    // Stops sending until every predicted result has come back, then gives the
    // block time to finish any request that produced no result.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (chars_owed != 0);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    // Writes the size limit and reads it straight back; the upper data bits
    // are noise that the register must drop.
    task automatic set_limit(input logic [15:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAX_SIZE_ADDR;
        pwdata <= {16'($urandom_range(0, 65535)), v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Builds a random string. Most strings mix unreserved text, other ASCII, raw
    // bytes and UTF-8-style lead/continuation sequences; a few sequences are cut short,
    // and one string in ten is raw noise over the whole byte range.
    task automatic fill_text();
        int         len;
        int         kind;
        int         span;
        int         keep;
        int         r;
        bit         noise;
        logic [7:0] lead;
        text_q.delete();
        len = $urandom_range(1, 12);
        noise = ($urandom_range(0, 9) == 0);
        while (text_q.size() < len)
        begin
            kind = noise ? 9 : $urandom_range(0, 9);
            if (kind < 4)
            begin
                r = $urandom_range(0, 65);
                if (r < 26)
                    text_q.push_back(8'h41 + 8'(r));
                else if (r < 52)
                    text_q.push_back(8'h61 + 8'(r - 26));
                else if (r < 62)
                    text_q.push_back(8'h30 + 8'(r - 52));
                else if (r == 62)
                    text_q.push_back(8'h2D);
                else if (r == 63)
                    text_q.push_back(8'h2E);
                else if (r == 64)
                    text_q.push_back(8'h5F);
                else
                    text_q.push_back(8'h7E);
            end
            else if (kind < 6)
                text_q.push_back(8'($urandom_range(0, 127)));
            else if (kind < 8)
            begin
                span = $urandom_range(2, 6);
                case (span)
                    2:       lead = 8'($urandom_range(8'hC2, 8'hDF));
                    3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
                    4:       lead = 8'($urandom_range(8'hF0, 8'hF7));
                    5:       lead = 8'($urandom_range(8'hF8, 8'hFB));
                    default: lead = 8'($urandom_range(8'hFC, 8'hFD));
                endcase
                text_q.push_back(lead);
                keep = ($urandom_range(0, 6) == 0) ? $urandom_range(0, span - 2) : span - 1;
                repeat (keep) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
            else
                text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int          target;
        logic [15:0] lim;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset limit of 4096. The lowest and highest byte,
        // unreserved characters and a lone byte above the lead-byte range.
        text_q = '{8'h00, 8'h30, 8'h7A, 8'h7E, 8'hFF};
        send_text();
        // An overlong lead that counts as a single byte, then a two-byte sequence
        // whose continuation is an unreserved letter but must still be escaped.
        text_q = '{8'hC0, 8'h5F, 8'hC3, 8'h41, 8'h2E};
        send_text();
        // A four-byte sequence cut off by the end of the string; state must clear.
        text_q = '{8'hF0, 8'h9F};
        send_text();

        // A zero limit: the only byte triggers the stop, and the end of the string
        // comes back as a status-only request flagged truncated.
        wait_for_drain();
        set_limit(16'd0);
        text_q = '{8'h61};
        send_text();

        // Room for four bytes: two literals fit, the two-byte sequence does not,
        // and everything after it is dropped up to the status-only end.
        wait_for_drain();
        set_limit(16'd4);
        text_q = '{8'h41, 8'h2D, 8'hC3, 8'h39, 8'h5A};
        send_text();

        // Largest limit, which equals the counter maximum. A six-byte lead reserves
        // its whole sequence, then the limit drops to three in the middle of it:
        // the reserved continuations still come out, the next check stops output.
        wait_for_drain();
        set_limit(16'hFFFF);
        send_byte(8'hFD, 1'b0);
        wait_for_drain();
        set_limit(16'd3);
        text_q = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h71, 8'h72};
        send_text();

        // Random part: four idle/stall mixes, each run twice, each segment under a
        // fresh limit. Every segment starts with the sender held off until all
        // results are in, which is also when the limit may be rewritten.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_for_drain();
            case (seg % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 87;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 87;
                end
                default:
                begin
                    idle_pct = 18;
                    stall_pct = 18;
                end
            endcase
            case (seg)
                0, 5:    lim = 16'hFFFF;
                1, 4:    lim = 16'($urandom_range(0, 24));
                2, 6:    lim = 16'($urandom_range(3, 60));
                default: lim = 16'($urandom_range(0, 65535));
            endcase
            set_limit(lim);
            target = bytes_sent + RANDOM_ITEMS / SEGMENTS;
            while (bytes_sent < target)
            begin
                fill_text();
                send_text();
            end
        end

        // All requests are in; wait for the last results and a quiet tail.
        wait_for_drain();

        $display("summary: %0d input bytes in %0d strings, %0d results checked, %0d truncated",
                 bytes_sent, strings_sent, results_checked, cut_results);
        $display("summary: limits from zero to the counter maximum, four idle/stall mixes");
        if (error_count == 0 && chars_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
